// ===== hw/rtl/mavg_pkg.sv =====
// Package for the moving average block: field widths and default settings.
// No dependencies; imported by moving_average_warmup.
`default_nettype none

package mavg_pkg;

  // Width of one input sample, two's complement.
  localparam int SampleW = 32;
  // Width of the average result and its fraction bits.
  localparam int AvgW = 40;
  localparam int FracW = 8;
  // Default number of samples in the full window.
  localparam int DefaultWindow = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/moving_average_warmup.sv =====
// Top level of the moving average block with warm-up.
// Depends on mavg_pkg for widths and the default window length.
`default_nettype none

// This block takes one signed 32-bit sample per request and returns the mean of
// the most recent samples as a signed value with 8 fraction bits, truncated
// toward zero, together with the number of samples that went into it. Until
// WINDOW samples have arrived the mean covers all samples seen so far; from then
// on it covers the last WINDOW samples. A sample is taken when in_valid_i is high
// and in_stall_o is low, and in_stall_o stays high while that sample is being
// worked on. The restoring divider makes one quotient bit per cycle of the sum
// (shifted up by the fraction bits) divided by the sample count. The oldest
// window entry is read at acceptance; the steps that follow subtract it from the
// running sum once the window is full (before that they count the new sample),
// add the new sample with the same shared adder, load the divider, divide, and
// restore the sign into the output register. The next request is accepted in
// the cycle after the result is loaded at the earliest, so a new sample is never
// taken before the last one is through. The result sits in an output register,
// so the next sample is accepted while a finished result still waits for
// out_stall_i to drop; if that result is still waiting when the next one is
// ready, the block holds in its final step until out_stall_i drops. The window
// store has no reset; only entries that were written are ever subtracted from
// the sum.
module moving_average_warmup
  import mavg_pkg::*;
#(
  parameter int WINDOW = DefaultWindow,
  localparam int CountW = $clog2(WINDOW + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [AvgW-1:0]         average_o,
  output logic [CountW-1:0]              samples_used_o
);

  // The sum needs enough headroom for WINDOW full-scale samples.
  localparam int SumW = SampleW + $clog2(WINDOW);
  // Dividend is the sum magnitude with the fraction bits appended.
  localparam int DvdW = SumW + FracW;
  localparam int BitW = $clog2(DvdW);
  localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CountW-1:0] WinCount = CountW'(WINDOW);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);
  localparam logic [BitW-1:0] LastBit = BitW'(DvdW - 1);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSub  = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state_q, state_d;

  // Window store, written and read in clocked blocks.
  logic signed [SampleW-1:0] win_q [WINDOW];
  logic signed [SampleW-1:0] old_q;
  logic signed [SampleW-1:0] sample_q;

  logic [SlotW-1:0]        slot_q;
  logic [CountW-1:0]       count_q;
  logic signed [SumW-1:0]  sum_q;

  logic [DvdW-1:0]         dvd_q;
  logic [CountW-1:0]       rem_q;
  logic [BitW-1:0]         bit_q;
  logic                    neg_q;

  logic                    out_valid_q;
  logic signed [AvgW-1:0]  avg_q;
  logic [CountW-1:0]       used_q;

  logic                    in_take;
  logic                    out_free;
  logic                    win_full;

  // Shared adder for the running sum: subtracts the oldest sample in the
  // subtract step and adds the new sample in the add step.
  logic [SumW-1:0]         add_b;
  logic                    add_cin;
  logic [SumW-1:0]         add_sum;

  // One restoring division step.
  logic [CountW:0]         trial;
  logic                    trial_ge;
  logic [CountW:0]         trial_diff;

  logic [SumW-1:0]         sum_mag;
  logic [AvgW-1:0]         quot;

  assign in_stall_o = (state_q != StIdle);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign win_full   = (count_q == WinCount);

  always_comb begin
    if (state_q == StSub) begin
      add_b   = ~SumW'(old_q);
      add_cin = 1'b1;
    end else begin
      add_b   = SumW'(sample_q);
      add_cin = 1'b0;
    end
    add_sum = SumW'(sum_q) + add_b + SumW'(add_cin);
  end

  always_comb begin
    trial      = {rem_q, dvd_q[DvdW-1]};
    trial_ge   = (trial >= {1'b0, count_q});
    trial_diff = trial - {1'b0, count_q};
  end

  assign sum_mag = sum_q[SumW-1] ? (~SumW'(sum_q) + SumW'(1)) : SumW'(sum_q);
  assign quot    = neg_q ? (~dvd_q[AvgW-1:0] + AvgW'(1)) : dvd_q[AvgW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_take) state_d = StSub;
      StSub:  state_d = StAdd;
      StAdd:  state_d = StLoad;
      StLoad: state_d = StDiv;
      StDiv:  if (bit_q == '0) state_d = StFin;
      StFin:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StSub: begin
          if (win_full) begin
            sum_q <= add_sum;
          end else begin
            count_q <= count_q + CountW'(1);
          end
        end
        StAdd: begin
          sum_q  <= add_sum;
          slot_q <= (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
        end
        default: begin
        end
      endcase
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: store, captured sample, divider and result.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
      old_q    <= win_q[slot_q];
    end
    if (state_q == StAdd) begin
      win_q[slot_q] <= sample_q;
    end
    case (state_q)
      StLoad: begin
        dvd_q <= {sum_mag, FracW'(0)};
        rem_q <= '0;
        bit_q <= LastBit;
        neg_q <= sum_q[SumW-1];
      end
      StDiv: begin
        dvd_q <= {dvd_q[DvdW-2:0], trial_ge};
        rem_q <= trial_ge ? trial_diff[CountW-1:0] : trial[CountW-1:0];
        bit_q <= bit_q - BitW'(1);
      end
      StFin: begin
        if (out_free) begin
          avg_q  <= quot;
          used_q <= count_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = avg_q;
  assign samples_used_o = used_q;

endmodule

`default_nettype wire
